FILE: rtl/timer_pool_expiry_scheduler_macros.svh
// Assertion macros shared by the timer pool RTL.
// Depends on clk_i and rst_ni being visible in the asserting module.
`ifndef TIMER_POOL_EXPIRY_SCHEDULER_MACROS_SVH
`define TIMER_POOL_EXPIRY_SCHEDULER_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define TPES_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define TPES_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

FILE: rtl/tpes_pkg.sv
// Types and constants of the timer pool expiry scheduler.
// No dependencies; used by the interfaces and the top level.
package tpes_pkg;

  localparam int KIND_W    = 2;
  localparam int SECS_W    = 22;
  localparam int SLOT_W    = 4;
  localparam int DIV_W     = 8;
  localparam int OUT_IDX_W = 4;

  localparam int TIMER_SLOTS_DEF = 16;
  localparam int REMAIN_BITS_DEF = 23;

  localparam logic [DIV_W-1:0]  DIV_RESET   = 8'd10;
  localparam logic [SECS_W-1:0] MAX_SECONDS = 22'd3682800;

  typedef enum logic [KIND_W-1:0] {
    KIND_TICK   = 2'd0,
    KIND_CREATE = 2'd1,
    KIND_DELETE = 2'd2
  } item_kind_e;

  typedef enum logic [KIND_W-1:0] {
    RES_CREATED = 2'd0,
    RES_FULL    = 2'd1,
    RES_EXPIRED = 2'd2
  } res_kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIND,
    ST_READ,
    ST_UPD,
    ST_FIN,
    ST_EMIT
  } state_e;

endpackage

FILE: rtl/tpes_item_if.sv
// Input channel of the timer pool: valid/ready plus one command word.
// Depends on tpes_pkg for field widths.
interface tpes_item_if;
  import tpes_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [SECS_W-1:0] delay_seconds;
  logic [SLOT_W-1:0] slot;

  modport source (output valid, output kind, output delay_seconds, output slot, input ready);
  modport sink   (input valid, input kind, input delay_seconds, input slot, output ready);
endinterface

FILE: rtl/tpes_result_if.sv
// Result channel of the timer pool: valid/ready plus one result word.
// Depends on tpes_pkg for field widths.
interface tpes_result_if;
  import tpes_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [KIND_W-1:0]    result_kind;
  logic [OUT_IDX_W-1:0] slot_index;
  logic                 last;

  modport source (output valid, output result_kind, output slot_index, output last, input ready);
  modport sink   (input valid, input result_kind, input slot_index, input last, output ready);
endinterface

FILE: rtl/tpes_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tpes_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

FILE: rtl/timer_pool_expiry_scheduler.sv
// Pool of TIMER_SLOTS one-shot timers counted in half-second steps. Delete and non-stepping
// ticks are handled in the idle state; a create scans the busy bits one slot a cycle until it
// finds a free slot or reaches the last one; a stepping tick walks the remaining-time RAM with
// one shared decrementer, reading then updating each slot, and the walk holds while the
// result port stalls. Expired slots come out in ascending order, last set on the final word.
module timer_pool_expiry_scheduler #(
  parameter int TIMER_SLOTS = tpes_pkg::TIMER_SLOTS_DEF,
  parameter int REMAIN_BITS = tpes_pkg::REMAIN_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  tpes_item_if.sink                  item_i,
  tpes_result_if.source              result_o,
  input  logic                       cfg_we_i,
  input  logic [tpes_pkg::DIV_W-1:0] cfg_wdata_i
);
  import tpes_pkg::*;
  `include "timer_pool_expiry_scheduler_macros.svh"

  localparam int SW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam logic [SW-1:0] LAST_IDX = SW'(TIMER_SLOTS - 1);
  localparam logic [31:0] REMAIN_MASK = 32'((33'd1 << REMAIN_BITS) - 33'd1);

  state_e                 state_q, state_d;
  logic [SW-1:0]          idx_q, idx_d;
  logic [TIMER_SLOTS-1:0] busy_q, busy_d;
  logic [DIV_W-1:0]       presc_q, presc_d;
  logic [DIV_W-1:0]       div_q;
  logic [REMAIN_BITS-1:0] steps_q, steps_d;
  logic                   pend_v_q, pend_v_d;
  logic [SW-1:0]          pend_idx_q, pend_idx_d;
  res_kind_e              res_kind_q, res_kind_d;
  logic [SW-1:0]          res_idx_q, res_idx_d;
  logic                   out_v_q, out_v_d;
  res_kind_e              out_kind_q, out_kind_d;
  logic [OUT_IDX_W-1:0]   out_idx_q, out_idx_d;
  logic                   out_last_q, out_last_d;

  logic                   accept, out_free, step_now, found, expire, stall, last_slot;
  logic [DIV_W-1:0]       div_eff;
  logic [SECS_W-1:0]      secs_c;
  logic [31:0]            steps_w, steps_sat;
  logic                   ram_we, ram_re;
  logic [REMAIN_BITS-1:0] ram_wdata, ram_rdata, rem_dec;
  logic [SW-1:0]          del_idx;
  logic                   del_ok;

  tpes_ram #(
    .WIDTH (REMAIN_BITS),
    .DEPTH (TIMER_SLOTS)
  ) u_remain_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  assign item_i.ready = (state_q == ST_IDLE);
  assign accept       = item_i.valid && item_i.ready;
  assign out_free     = !out_v_q || result_o.ready;
  assign last_slot    = (idx_q == LAST_IDX);

  assign div_eff  = (div_q == '0) ? DIV_W'(1) : div_q;
  assign step_now = ({1'b0, presc_q} + 9'd1) >= {1'b0, div_eff};

  // Clamp seconds, double into steps, force at least one, then fit the counter.
  assign secs_c    = (item_i.delay_seconds > MAX_SECONDS) ? MAX_SECONDS : item_i.delay_seconds;
  assign steps_w   = (secs_c == '0) ? 32'd1 : {9'd0, secs_c, 1'b0};
  assign steps_sat = (steps_w > REMAIN_MASK) ? REMAIN_MASK : steps_w;
  assign steps_d   = REMAIN_BITS'(steps_sat);

  assign del_idx = SW'(item_i.slot);
  assign del_ok  = (32'(item_i.slot) < 32'(TIMER_SLOTS));

  // Shared decrement and zero compare for the step scan.
  assign rem_dec = ram_rdata - REMAIN_BITS'(1);
  assign found   = !busy_q[idx_q];
  assign expire  = busy_q[idx_q] && (rem_dec == '0);
  assign stall   = expire && pend_v_q && !out_free;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (item_kind_e'(item_i.kind))
            KIND_TICK:   state_d = step_now ? ST_READ : ST_IDLE;
            KIND_CREATE: state_d = ST_FIND;
            default:     state_d = ST_IDLE;
          endcase
        end
      end
      ST_FIND: begin
        if (found || last_slot) begin
          state_d = ST_EMIT;
        end
      end
      ST_READ: state_d = ST_UPD;
      ST_UPD: begin
        if (!stall) begin
          state_d = last_slot ? ST_FIN : ST_READ;
        end
      end
      ST_FIN:  state_d = pend_v_q ? ST_EMIT : ST_IDLE;
      ST_EMIT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and output control.
  always_comb begin
    idx_d      = idx_q;
    busy_d     = busy_q;
    presc_d    = presc_q;
    pend_v_d   = pend_v_q;
    pend_idx_d = pend_idx_q;
    res_kind_d = res_kind_q;
    res_idx_d  = res_idx_q;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_wdata  = steps_q;
    out_v_d    = out_v_q && !result_o.ready;
    out_kind_d = out_kind_q;
    out_idx_d  = out_idx_q;
    out_last_d = out_last_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (item_kind_e'(item_i.kind))
            KIND_TICK: begin
              presc_d = step_now ? '0 : presc_q + DIV_W'(1);
            end
            KIND_DELETE: begin
              if (del_ok) begin
                busy_d[del_idx] = 1'b0;
              end
            end
            default: ;
          endcase
        end
      end
      ST_FIND: begin
        if (found) begin
          ram_we         = 1'b1;
          busy_d[idx_q]  = 1'b1;
          res_kind_d     = RES_CREATED;
          res_idx_d      = idx_q;
          idx_d          = '0;
        end else if (last_slot) begin
          res_kind_d = RES_FULL;
          res_idx_d  = '0;
          idx_d      = '0;
        end else begin
          idx_d = idx_q + SW'(1);
        end
      end
      ST_READ: ram_re = 1'b1;
      ST_UPD: begin
        ram_wdata = rem_dec;
        if (!stall) begin
          ram_we = busy_q[idx_q];
          if (expire) begin
            busy_d[idx_q] = 1'b0;
            // Flush the previous expiry; it is not the last one.
            if (pend_v_q) begin
              out_v_d    = 1'b1;
              out_kind_d = RES_EXPIRED;
              out_idx_d  = OUT_IDX_W'(pend_idx_q);
              out_last_d = 1'b0;
            end
            pend_v_d   = 1'b1;
            pend_idx_d = idx_q;
          end
          idx_d = last_slot ? '0 : idx_q + SW'(1);
        end
      end
      ST_FIN: begin
        pend_v_d   = 1'b0;
        res_kind_d = RES_EXPIRED;
        res_idx_d  = pend_idx_q;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_v_d    = 1'b1;
          out_kind_d = res_kind_q;
          out_idx_d  = OUT_IDX_W'(res_idx_q);
          out_last_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      idx_q    <= '0;
      busy_q   <= '0;
      presc_q  <= '0;
      div_q    <= DIV_RESET;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      busy_q   <= busy_d;
      presc_q  <= presc_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
      if (cfg_we_i) begin
        div_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      steps_q <= steps_d;
    end
    pend_idx_q <= pend_idx_d;
    res_kind_q <= res_kind_d;
    res_idx_q  <= res_idx_d;
    out_kind_q <= out_kind_d;
    out_idx_q  <= out_idx_d;
    out_last_q <= out_last_d;
  end

  assign result_o.valid       = out_v_q;
  assign result_o.result_kind = out_kind_q;
  assign result_o.slot_index  = out_idx_q;
  assign result_o.last        = out_last_q;

  `TPES_ASSERT(a_full_all_busy, (state_q == ST_EMIT && res_kind_q == RES_FULL) |-> (&busy_q), "pool full reported with a free slot")
  `TPES_ASSERT(a_idle_idx_zero, (state_q == ST_IDLE) |-> (idx_q == '0), "scan index not rewound at idle")
  `TPES_ASSERT_NEVER(a_pend_outside_scan, pend_v_q && (state_q == ST_IDLE || state_q == ST_FIND || state_q == ST_EMIT), "pending expiry outside a step scan")
  `TPES_ASSERT(a_expire_frees, (state_q == ST_UPD && expire && !stall) |=> !busy_q[$past(idx_q)], "expired slot still busy")

endmodule
